@@ sv/stat_pkg.sv @@
// ----------------------------------------------------------------------------
// stat_pkg: shared types for the sorted term accumulation table
// Beat formats, the table entry layout and the control state encoding.
// ----------------------------------------------------------------------------
package stat_pkg;

  localparam int COEF_IN_W  = 16;
  localparam int COEF_ACC_W = 32;
  localparam int EXP_W      = 10;

  localparam logic [COEF_ACC_W-1:0] COEF_MAX = 32'h7fff_ffff;
  localparam logic [COEF_ACC_W-1:0] COEF_MIN = 32'h8000_0000;

  typedef struct packed {
    logic signed [COEF_IN_W-1:0] term_coefficient;
    logic [EXP_W-1:0]            term_exponent;
    logic                        final_term;
  } stat_in_t;

  typedef struct packed {
    logic signed [COEF_ACC_W-1:0] out_coefficient;
    logic [EXP_W-1:0]             out_exponent;
    logic                         last_of_run;
    logic                         zero_polynomial;
    logic                         overflowed;
  } stat_out_t;

  // One row of the table memory.
  typedef struct packed {
    logic [EXP_W-1:0]             exponent;
    logic signed [COEF_ACC_W-1:0] coefficient;
  } stat_entry_t;

  localparam int ENTRY_W = $bits(stat_entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_PLACE,
    ST_ELOAD,
    ST_EMIT
  } stat_state_t;

endpackage

@@ sv/stat_ram.sv @@
// ----------------------------------------------------------------------------
// stat_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module stat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/sorted_term_accumulate_table_top.sv @@
// ----------------------------------------------------------------------------
// sorted_term_accumulate_table_top: sorted polynomial term accumulator
//
//   channel | ports                           | beat
//   --------+---------------------------------+-----------------------------
//   in      | in_valid, in_ready, in_data     | one term (stat_in_t)
//   out     | out_valid, out_ready, out_data  | one emitted term (stat_out_t)
//
// Terms live in one RAM, sorted by descending exponent; a fill count marks
// the valid rows. A term whose coefficient is zero is taken without a scan.
// Else rows are scanned to find the match or the insertion point; a match
// is summed in place, and a new term is placed in its own row after the
// tail below it is shifted down one row per cycle through the RAM port; an
// empty table places at once. A final term starts an emission, which the
// output can stall, and the input waits for the whole emission. Reset
// (rst_n, synchronous) empties the table at once; no clearing pass is
// needed.
// ----------------------------------------------------------------------------
module sorted_term_accumulate_table_top
  import stat_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  stat_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output stat_out_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE        = CW'(1);
  localparam logic [CW-1:0] TWO        = CW'(2);

  stat_state_t state_r, state_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic          ovf_r, ovf_nxt;

  logic signed [COEF_IN_W-1:0] coef_r, coef_nxt;
  logic [EXP_W-1:0]            exp_r, exp_nxt;
  logic                        fin_r, fin_nxt;

  stat_entry_t pend_r, pend_nxt;
  logic        have_pend_r, have_pend_nxt;

  logic      out_valid_r, out_valid_nxt;
  stat_out_t out_r, out_nxt;

  logic        ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  stat_entry_t ram_wdata, ram_rdata;

  stat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Decode of the row just read and of the current term.
  logic                  in_fire, in_zero;
  logic                  hit_eq, hit_lt, scan_end, full;
  logic                  shift_last, e_more, e_nz, can_push;
  logic signed [COEF_ACC_W:0] sum;
  logic [COEF_ACC_W-1:0] sat_sum;
  stat_entry_t           new_entry;

  assign in_ready   = (state_r == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign in_zero    = (in_data.term_coefficient == '0);
  assign hit_eq     = (ram_rdata.exponent == exp_r);
  assign hit_lt     = (ram_rdata.exponent < exp_r);
  assign scan_end   = ((idx_r + ONE) == count_r);
  assign full       = (count_r == FULL_COUNT);
  assign shift_last = ((idx_r - ONE) == pos_r);
  assign e_more     = (idx_r < count_r);
  assign e_nz       = (ram_rdata.coefficient != '0);
  assign can_push   = !out_valid_r || out_ready;

  assign sum = {ram_rdata.coefficient[COEF_ACC_W-1], ram_rdata.coefficient}
             + {{(COEF_ACC_W + 1 - COEF_IN_W){coef_r[COEF_IN_W-1]}}, coef_r};
  assign sat_sum = (sum[COEF_ACC_W] != sum[COEF_ACC_W-1])
                 ? (sum[COEF_ACC_W] ? COEF_MIN : COEF_MAX)
                 : sum[COEF_ACC_W-1:0];

  assign new_entry.exponent    = exp_r;
  assign new_entry.coefficient =
      {{(COEF_ACC_W - COEF_IN_W){coef_r[COEF_IN_W-1]}}, coef_r};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_zero) begin
            state_nxt = in_data.final_term ? ST_ELOAD : ST_IDLE;
          end else if (count_r == '0) begin
            state_nxt = ST_PLACE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit_eq) begin
          state_nxt = fin_r ? ST_ELOAD : ST_IDLE;
        end else if (hit_lt || scan_end) begin
          if (full) begin
            state_nxt = fin_r ? ST_ELOAD : ST_IDLE;
          end else begin
            state_nxt = hit_lt ? ST_SHIFT : ST_PLACE;
          end
        end
      end
      ST_SHIFT: begin
        if (shift_last) begin
          state_nxt = ST_PLACE;
        end
      end
      ST_PLACE: state_nxt = fin_r ? ST_ELOAD : ST_IDLE;
      ST_ELOAD: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!e_more && can_push) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, RAM control and output register.
  always_comb begin
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    ovf_nxt       = ovf_r;
    coef_nxt      = coef_r;
    exp_nxt       = exp_r;
    fin_nxt       = fin_r;
    pend_nxt      = pend_r;
    have_pend_nxt = have_pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r[AW-1:0];
    ram_wdata     = new_entry;
    ram_raddr     = idx_r[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        ram_raddr = '0;
        if (in_fire) begin
          coef_nxt = in_data.term_coefficient;
          exp_nxt  = in_data.term_exponent;
          fin_nxt  = in_data.final_term;
          idx_nxt  = '0;
          pos_nxt  = '0;
        end
      end
      ST_SCAN: begin
        if (hit_eq) begin
          ram_we                = 1'b1;
          ram_wdata.exponent    = ram_rdata.exponent;
          ram_wdata.coefficient = sat_sum;
        end else if ((hit_lt || scan_end) && full) begin
          ovf_nxt = 1'b1;
        end else if (hit_lt) begin
          // Open a gap at this row: move the tail down, last row first.
          pos_nxt   = idx_r;
          idx_nxt   = count_r;
          ram_raddr = AW'(count_r - ONE);
        end else if (scan_end) begin
          pos_nxt = count_r;
        end else begin
          idx_nxt   = idx_r + ONE;
          ram_raddr = AW'(idx_r + ONE);
        end
      end
      ST_SHIFT: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        if (!shift_last) begin
          idx_nxt   = idx_r - ONE;
          ram_raddr = AW'(idx_r - TWO);
        end
      end
      ST_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r[AW-1:0];
        count_nxt = count_r + ONE;
      end
      ST_ELOAD: begin
        idx_nxt       = '0;
        ram_raddr     = '0;
        have_pend_nxt = 1'b0;
      end
      ST_EMIT: begin
        // One nonzero row is held back so that the last one can be flagged.
        if (e_more) begin
          if (!e_nz) begin
            idx_nxt = idx_r + ONE;
          end else if (!have_pend_r) begin
            pend_nxt      = ram_rdata;
            have_pend_nxt = 1'b1;
            idx_nxt       = idx_r + ONE;
          end else if (can_push) begin
            out_valid_nxt           = 1'b1;
            out_nxt.out_coefficient = pend_r.coefficient;
            out_nxt.out_exponent    = pend_r.exponent;
            out_nxt.last_of_run     = 1'b0;
            out_nxt.zero_polynomial = 1'b0;
            out_nxt.overflowed      = ovf_r;
            pend_nxt                = ram_rdata;
            idx_nxt                 = idx_r + ONE;
          end
        end else if (can_push) begin
          out_valid_nxt           = 1'b1;
          out_nxt.out_coefficient = have_pend_r ? pend_r.coefficient : '0;
          out_nxt.out_exponent    = have_pend_r ? pend_r.exponent : '0;
          out_nxt.last_of_run     = 1'b1;
          out_nxt.zero_polynomial = !have_pend_r;
          out_nxt.overflowed      = ovf_r;
          have_pend_nxt           = 1'b0;
          count_nxt               = '0;
          ovf_nxt                 = 1'b0;
        end
        ram_raddr = idx_nxt[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      have_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      have_pend_r <= have_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    pos_r  <= pos_nxt;
    coef_r <= coef_nxt;
    exp_r  <= exp_nxt;
    fin_r  <= fin_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The fill count never passes the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("table fill count exceeds depth");

  // A tail shift always moves rows strictly below the insertion point.
  a_shift_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) |-> (idx_r > pos_r) && (idx_r < FULL_COUNT))
    else $error("tail shift pointer out of order");

  // Emission never writes the table.
  a_emit_readonly: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT || state_r == ST_ELOAD) |-> !ram_we)
    else $error("table written during emission");

  // The closing beat of an emission empties the table and the flag.
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && !e_more && can_push) |=>
      (count_r == '0) && !ovf_r && out_valid_r && out_r.last_of_run)
    else $error("emission did not close the run");

  // Only nonzero rows are held for output.
  a_pend_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    have_pend_r |-> (pend_r.coefficient != '0))
    else $error("held row has zero coefficient");

endmodule

@@ dv/sorted_term_accumulate_table_top_test.sv @@
// ----------------------------------------------------------------------------
// sorted_term_accumulate_table_top_test: self-checking bench for the term table
// Drives polynomial terms through the valid/ready input channel and compares
// every emitted beat with a software table that sorts, merges and saturates
// the same terms. Covers edge exponents and coefficients, cancellation,
// large accumulations in both directions, table overflow, zero polynomials,
// random stalls on both channels, a long output hold-off and a full drain.
// ----------------------------------------------------------------------------
module sorted_term_accumulate_table_top_test import stat_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          TABLE_DEPTH   = 32;
  localparam int          CLK_HALF      = 5;
  localparam int          CYCLE_LIMIT   = 3_000_000;
  localparam int          BIG_TERMS     = 4;
  localparam int          RANDOM_ITEMS  = 100;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          PRINT_CAP     = 100;
  localparam longint      ACC_HI        = 64'sd2147483647;
  localparam longint      ACC_LO        = -64'sd2147483648;
  localparam logic signed [COEF_IN_W-1:0] COEF_IN_MAX = 16'sh7fff;
  localparam logic signed [COEF_IN_W-1:0] COEF_IN_MIN = 16'sh8000;
  localparam logic [EXP_W-1:0]            EXP_TOP     = 10'd1023;

  typedef enum int {
    RUN_NARROW,
    RUN_WIDE,
    RUN_EDGE,
    RUN_FULL
  } run_kind_t;

  // Software copy of the sorted table and the beats it is due to emit.
  class term_table_model;
    logic [EXP_W-1:0]             row_exp  [TABLE_DEPTH];
    logic signed [COEF_ACC_W-1:0] row_coef [TABLE_DEPTH];
    int                           row_count;
    logic                         dropped;
    stat_out_t                    expected_terms[$];
    int                           mismatches;
    int                           beat_count;

    function new();
      clear_table();
      mismatches = 0;
      beat_count = 0;
    endfunction

    function void clear_table();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        row_exp[i]  = '0;
        row_coef[i] = '0;
      end
      row_count = 0;
      dropped   = 1'b0;
    endfunction

    function logic signed [COEF_ACC_W-1:0] sat_sum(logic signed [COEF_ACC_W-1:0] acc,
                                                   logic signed [COEF_IN_W-1:0] add);
      longint s;
      s = longint'(acc) + longint'(add);
      if (s > ACC_HI) return COEF_MAX;
      if (s < ACC_LO) return COEF_MIN;
      return s[COEF_ACC_W-1:0];
    endfunction

    function void merge_term(logic signed [COEF_IN_W-1:0] c, logic [EXP_W-1:0] e);
      int pos;
      if (c == 0) return;
      pos = row_count;
      for (int i = 0; i < row_count; i++) begin
        if (row_exp[i] == e) begin
          row_coef[i] = sat_sum(row_coef[i], c);
          return;
        end
        if (row_exp[i] < e) begin
          pos = i;
          break;
        end
      end
      if (row_count >= TABLE_DEPTH) begin
        dropped = 1'b1;
        return;
      end
      for (int i = row_count; i > pos; i--) begin
        row_exp[i]  = row_exp[i-1];
        row_coef[i] = row_coef[i-1];
      end
      row_exp[pos]  = e;
      row_coef[pos] = COEF_ACC_W'(c);
      row_count++;
    endfunction

    function void note_term(stat_in_t t);
      int        nz;
      int        k;
      stat_out_t b;
      merge_term(t.term_coefficient, t.term_exponent);
      if (!t.final_term) return;
      nz = 0;
      for (int i = 0; i < row_count; i++) begin
        if (row_coef[i] != 0) nz++;
      end
      b = '0;
      b.overflowed = dropped;
      if (nz == 0) begin
        b.last_of_run     = 1'b1;
        b.zero_polynomial = 1'b1;
        expected_terms.push_back(b);
      end else begin
        k = 0;
        for (int i = 0; i < row_count; i++) begin
          if (row_coef[i] != 0) begin
            k++;
            b.out_coefficient = row_coef[i];
            b.out_exponent    = row_exp[i];
            b.last_of_run     = (k == nz);
            expected_terms.push_back(b);
          end
        end
      end
      clear_table();
    endfunction

    function int pending();
      return expected_terms.size();
    endfunction

    task report_mismatch(string msg);
      // Keep the log bounded if the design is badly broken.
      if (mismatches < PRINT_CAP) $display("MISMATCH beat %0d: %s", beat_count, msg);
      mismatches++;
    endtask

    task check_beat(stat_out_t got);
      stat_out_t want;
      if (expected_terms.size() == 0) begin
        report_mismatch($sformatf("unexpected beat coef %0d exp %0d",
                                  got.out_coefficient, got.out_exponent));
        beat_count++;
        return;
      end
      want = expected_terms.pop_front();
      if (got.out_coefficient !== want.out_coefficient)
        report_mismatch($sformatf("out_coefficient got %0d expected %0d",
                                  got.out_coefficient, want.out_coefficient));
      if (got.out_exponent !== want.out_exponent)
        report_mismatch($sformatf("out_exponent got %0d expected %0d",
                                  got.out_exponent, want.out_exponent));
      if (got.last_of_run !== want.last_of_run)
        report_mismatch($sformatf("last_of_run got %b expected %b",
                                  got.last_of_run, want.last_of_run));
      if (got.zero_polynomial !== want.zero_polynomial)
        report_mismatch($sformatf("zero_polynomial got %b expected %b",
                                  got.zero_polynomial, want.zero_polynomial));
      if (got.overflowed !== want.overflowed)
        report_mismatch($sformatf("overflowed got %b expected %b",
                                  got.overflowed, want.overflowed));
      beat_count++;
    endtask

    task finish_check();
      if (expected_terms.size() != 0)
        report_mismatch($sformatf("%0d expected beats never arrived", expected_terms.size()));
    endtask
  endclass

  logic      clk   = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid;
  logic      in_ready;
  stat_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  stat_out_t out_data;

  term_table_model sb;
  bit              no_idle      = 1'b0;
  int              hold_request = 0;
  int              cycle_count;

  sorted_term_accumulate_table_top #(
    .DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #CLK_HALF clk = ~clk;

  // Both monitors see pre-edge values, since every driver uses nonblocking updates.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_term(in_data);
    if (rst_n && out_valid && out_ready) sb.check_beat(out_data);
  end

  // Offers one term, possibly after a random idle burst, and returns on its accept edge.
  // The caller must either send again or drop valid in the same time step.
  task send_term(input logic signed [COEF_IN_W-1:0] c, input logic [EXP_W-1:0] e,
                 input logic fin);
    stat_in_t t;
    t.term_coefficient = c;
    t.term_exponent    = e;
    t.final_term       = fin;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Receiver: random ready bursts, plus a long hold-off on request.
  initial begin
    out_ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request != 0) begin
        out_ready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end else if (!no_idle && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("sorted_term_accumulate_table_top_test NOT OK");
    $finish;
  end

  initial begin
    int                          real_items;
    int                          run_idx;
    int                          run_len;
    int                          pick;
    int                          v;
    run_kind_t                   kind;
    logic signed [COEF_IN_W-1:0] c;
    logic [EXP_W-1:0]            e;
    logic [EXP_W-1:0]            base;
    logic [EXP_W-1:0]            first_e;
    logic                        fin;

    sb = new();
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table at the final term gives the zero polynomial.
    send_term(16'sd0, EXP_TOP, 1'b1);
    // Extremes, head merge, middle insert, cancellation and an ignored term.
    send_term(COEF_IN_MAX, EXP_TOP, 1'b0);
    send_term(COEF_IN_MIN, 10'd0, 1'b0);
    send_term(16'sd3, EXP_TOP, 1'b0);
    send_term(16'sd1, 10'd512, 1'b0);
    send_term(-16'sd1, 10'd512, 1'b0);
    send_term(16'sd0, 10'd300, 1'b0);
    send_term(16'sd5, 10'd7, 1'b1);
    // Everything cancels, so only the zero polynomial comes out.
    send_term(16'sd100, 10'd5, 1'b0);
    send_term(-16'sd100, 10'd5, 1'b1);
    // A zero final term still triggers the emission.
    send_term(16'sd7, 10'd9, 1'b0);
    send_term(16'sd0, 10'd9, 1'b1);
    send_term(-16'sd1, EXP_TOP, 1'b1);

    // Pile extreme terms onto one positive and one negative entry, then step
    // each back by one.
    no_idle = 1'b1;
    for (int n = 0; n < BIG_TERMS; n++) begin
      send_term(COEF_IN_MAX, 10'd100, 1'b0);
      send_term(COEF_IN_MIN, 10'd3, 1'b0);
    end
    send_term(-16'sd1, 10'd100, 1'b0);
    send_term(16'sd1, 10'd3, 1'b0);
    send_term(16'sd0, 10'd50, 1'b1);
    no_idle = 1'b0;

    real_items = 0;
    run_idx    = 0;
    while (real_items < RANDOM_ITEMS || run_idx <= 8) begin
      if (run_idx == 0 || (run_idx != 3 && $urandom_range(0, 5) == 0)) begin
        kind    = RUN_FULL;
        run_len = $urandom_range(TABLE_DEPTH + 2, TABLE_DEPTH + 8);
      end else begin
        pick    = $urandom_range(0, 2);
        kind    = (pick == 0) ? RUN_NARROW : (pick == 1) ? RUN_WIDE : RUN_EDGE;
        run_len = (run_idx == 3) ? $urandom_range(1, 4) : $urandom_range(1, 8);
      end
      // Hold the output off long enough that the table stalls its input.
      if (run_idx == 3) hold_request = HOLD_CYCLES;
      // Let the block drain completely before carrying on.
      if (run_idx == 8) begin
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      base    = EXP_W'($urandom_range(0, 1020));
      first_e = '0;
      for (int k = 0; k < run_len; k++) begin
        fin  = (k == run_len - 1);
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          c = 16'sd0;
        end else if (pick == 1) begin
          c = COEF_IN_MAX;
        end else if (pick == 2) begin
          c = COEF_IN_MIN;
        end else if (pick <= 5) begin
          v = $urandom_range(0, 16);
          c = COEF_IN_W'(v - 8);
        end else begin
          c = COEF_IN_W'($urandom_range(0, 16'hffff));
        end
        case (kind)
          RUN_NARROW: begin
            e = EXP_W'(base + $urandom_range(0, 3));
          end
          RUN_EDGE: begin
            pick = $urandom_range(0, 3);
            e = (pick == 0) ? 10'd0 : (pick == 1) ? 10'd1 : (pick == 2) ? 10'd1022 : EXP_TOP;
          end
          default: begin
            e = EXP_W'($urandom_range(0, 1023));
          end
        endcase
        // On a full table a known exponent must still merge.
        if (kind == RUN_FULL && k == 0) first_e = e;
        if (kind == RUN_FULL && k == run_len - 2) e = first_e;
        send_term(c, e, fin);
        if (c != 0 || fin) real_items++;
      end
      run_idx++;
      if (real_items >= (RANDOM_ITEMS * 3) / 4) no_idle = 1'b1;
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (4 * TABLE_DEPTH) @(posedge clk);
    sb.finish_check();
    if (sb.mismatches == 0) begin
      $display("sorted_term_accumulate_table_top_test OK");
    end else begin
      $display("sorted_term_accumulate_table_top_test NOT OK");
    end
    $finish;
  end

endmodule
